@@ src/pbmpd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PackBits multi-plane decoder package
// Shared widths, codes, reset values and the control and result types.
// ----------------------------------------------------------------------------
package pbmpd_pkg;

   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 8;
   localparam int PIDX_W     = 2;
   localparam int POFF_W     = 14;
   localparam int SIZE_REG_W = 15;
   localparam int COUNT_W    = 3;
   localparam int PREFIX_W   = 3;
   localparam int PLANE_W    = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   localparam logic [BYTE_W-1:0]     HDR_REPEAT   = 8'h80;
   localparam logic [LEN_W-1:0]      REPEAT_BIAS  = 8'd3;
   localparam logic [PREFIX_W-1:0]   PREFIX_MAX   = 3'd4;

   localparam logic [SIZE_REG_W-1:0] RST_PLANE_SIZE  = 15'd1024;
   localparam logic [COUNT_W-1:0]    RST_PLANE_COUNT = 3'd3;
   localparam logic [PREFIX_W-1:0]   RST_PREFIX      = 3'd0;
   localparam logic                  RST_TOLERATE    = 1'b0;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_TRUNCATED = 2'd1;
   localparam logic [1:0] ST_MISSING   = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PLANE_SIZE,
      REG_PLANE_COUNT,
      REG_PREFIX_BYTES,
      REG_TOLERATE_LAST
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_PREFIX,
      PH_HEADER,
      PH_LITERAL,
      PH_REPEAT
   } phase_type;

   typedef struct packed {
      phase_type            phase;
      logic [PREFIX_W-1:0]  prefix_seen;
      logic [LEN_W-1:0]     literal_left;
      logic [LEN_W-1:0]     repeat_count;
      logic [PLANE_W-1:0]   plane;
   } ctl_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] run_value;
      logic [LEN_W-1:0]  run_length;
      logic [PIDX_W-1:0] plane_index;
      logic [POFF_W-1:0] plane_offset;
      logic              plane_done;
      logic              final_res;
      logic [1:0]        status;
   } rsp_data_type;

endpackage

@@ src/pbmpd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PackBits multi-plane decoder channels
// Valid/ready channels for compressed bytes in and decoded runs out.
// ----------------------------------------------------------------------------
interface pbmpd_req_if import pbmpd_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] src_byte;
   logic              src_last;

   modport source (output valid, src_byte, src_last, input ready);
   modport sink (input valid, src_byte, src_last, output ready);
endinterface

interface pbmpd_rsp_if import pbmpd_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] run_value;
   logic [LEN_W-1:0]  run_length;
   logic [PIDX_W-1:0] plane_index;
   logic [POFF_W-1:0] plane_offset;
   logic              plane_done;
   logic              final_res;
   logic [1:0]        status;

   modport source (output valid, run_value, run_length, plane_index, plane_offset,
                   plane_done, final_res, status, input ready);
   modport sink (input valid, run_value, run_length, plane_index, plane_offset,
                 plane_done, final_res, status, output ready);
endinterface

@@ src/packbits_multi_plane_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PackBits multi-plane decoder
// Skips a byte prefix, then decodes PackBits runs into consecutive planes.
// ----------------------------------------------------------------------------
// Flow: an accepted item sits in the input register and is decoded into the
// result register, where its result appears, once that register is free.
// Throughput: one compressed byte per cycle unless the result register is held;
// each byte takes a single pass through header, run-clamp and offset logic.
// Reset: decoder returns to prefix skip at plane 0, registers take defaults.
module packbits_multi_plane_decoder_top import pbmpd_pkg::*; #(
   parameter int MAX_PLANE_BYTES = 16384,
   parameter int MAX_PLANES      = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   pbmpd_req_if.sink             req_if,
   pbmpd_rsp_if.source           rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int OFF_W = $clog2(MAX_PLANE_BYTES + 1);

   logic [SIZE_REG_W-1:0] plane_size_ff;
   logic [COUNT_W-1:0]    plane_count_ff;
   logic [PREFIX_W-1:0]   prefix_bytes_ff;
   logic                  tolerate_last_ff;

   logic                  in_valid_ff;
   logic [BYTE_W-1:0]     in_byte_ff;
   logic                  in_last_ff;

   ctl_state_type         state_ff;
   ctl_state_type         state_in;
   logic [OFF_W-1:0]      offset_ff;
   logic [OFF_W-1:0]      offset_in;

   logic                  rsp_valid_ff;
   rsp_data_type          rsp_data_ff;
   logic                  res_valid;
   rsp_data_type          res_data;

   logic                  advance;
   logic                  step_fire;

   // The result register frees up when empty or taken this cycle.
   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign step_fire    = in_valid_ff && advance;
   assign req_if.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_size_ff    <= RST_PLANE_SIZE;
         plane_count_ff   <= RST_PLANE_COUNT;
         prefix_bytes_ff  <= RST_PREFIX;
         tolerate_last_ff <= RST_TOLERATE;
      end else if (csr_we) begin
         case (csr_index)
            REG_PLANE_SIZE:    plane_size_ff    <= csr_wdata[SIZE_REG_W-1:0];
            REG_PLANE_COUNT:   plane_count_ff   <= csr_wdata[COUNT_W-1:0];
            REG_PREFIX_BYTES:  prefix_bytes_ff  <= csr_wdata[PREFIX_W-1:0];
            REG_TOLERATE_LAST: tolerate_last_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_byte_ff <= req_if.src_byte;
         in_last_ff <= req_if.src_last;
      end
   end

   pbmpd_step #(
      .MAX_PLANE_BYTES (MAX_PLANE_BYTES),
      .MAX_PLANES      (MAX_PLANES)
   ) u_step (
      .cfg_plane_size    (plane_size_ff),
      .cfg_plane_count   (plane_count_ff),
      .cfg_prefix_bytes  (prefix_bytes_ff),
      .cfg_tolerate_last (tolerate_last_ff),
      .state_cur         (state_ff),
      .offset_cur        (offset_ff),
      .src_byte          (in_byte_ff),
      .src_last          (in_last_ff),
      .state_nxt         (state_in),
      .offset_nxt        (offset_in),
      .res_valid         (res_valid),
      .res               (res_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '{phase: PH_PREFIX, prefix_seen: '0, literal_left: '0,
                           repeat_count: '0, plane: '0};
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (step_fire) begin
         state_ff     <= state_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= res_valid;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire && res_valid) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.run_value    = rsp_data_ff.run_value;
   assign rsp_if.run_length   = rsp_data_ff.run_length;
   assign rsp_if.plane_index  = rsp_data_ff.plane_index;
   assign rsp_if.plane_offset = rsp_data_ff.plane_offset;
   assign rsp_if.plane_done   = rsp_data_ff.plane_done;
   assign rsp_if.final_res    = rsp_data_ff.final_res;
   assign rsp_if.status       = rsp_data_ff.status;

   // The final item always leaves the decoder back at its start.
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (step_fire && in_last_ff) |=>
         (state_ff.phase == PH_PREFIX && state_ff.plane == '0 && offset_ff == '0))
      else $error("decoder state not cleared after final item");

   // A result that is not final always carries a run.
   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.final_res) |-> (rsp_data_ff.run_length != '0))
      else $error("empty run on a non-final result");

   // Error status only appears on the final result.
   a_status_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != ST_OK) |-> rsp_data_ff.final_res)
      else $error("error status on a non-final result");

   // The plane counter never runs past the largest plane count.
   a_plane_bound: assert property (@(posedge clock) disable iff (reset)
      step_fire |=> (state_ff.plane <= PLANE_W'(MAX_PLANES)))
      else $error("plane counter out of range");

endmodule

@@ src/pbmpd_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PackBits multi-plane decoder step
// Next decoder state and the optional run or end-status result for one compressed byte.
// ----------------------------------------------------------------------------
module pbmpd_step import pbmpd_pkg::*; #(
   parameter int MAX_PLANE_BYTES = 16384,
   parameter int MAX_PLANES      = 4,
   localparam int OFF_W = $clog2(MAX_PLANE_BYTES + 1)
) (
   input  logic [SIZE_REG_W-1:0] cfg_plane_size,
   input  logic [COUNT_W-1:0]    cfg_plane_count,
   input  logic [PREFIX_W-1:0]   cfg_prefix_bytes,
   input  logic                  cfg_tolerate_last,
   input  ctl_state_type         state_cur,
   input  logic [OFF_W-1:0]      offset_cur,
   input  logic [BYTE_W-1:0]     src_byte,
   input  logic                  src_last,
   output ctl_state_type         state_nxt,
   output logic [OFF_W-1:0]      offset_nxt,
   output logic                  res_valid,
   output rsp_data_type          res
);

   localparam int CMP_W = (OFF_W > SIZE_REG_W) ? OFF_W : SIZE_REG_W;
   localparam int N_W   = (OFF_W > LEN_W) ? OFF_W : LEN_W;

   logic [CMP_W-1:0]    size_ext;
   logic [OFF_W-1:0]    size;
   logic [COUNT_W-1:0]  count;
   logic [PREFIX_W-1:0] prefix_lim;
   logic [OFF_W-1:0]    rem;
   logic [N_W-1:0]      rep_ext;
   logic [N_W-1:0]      rem_ext;
   logic [N_W-1:0]      n_ext;
   logic [OFF_W-1:0]    off_adv;
   logic                emit;
   ctl_state_type       st;
   logic [OFF_W-1:0]    off;

   // Register values outside their legal range are saturated here.
   always_comb begin
      size_ext = CMP_W'(cfg_plane_size);
      if (size_ext == '0) begin
         size = OFF_W'(1);
      end else if (size_ext > CMP_W'(MAX_PLANE_BYTES)) begin
         size = OFF_W'(MAX_PLANE_BYTES);
      end else begin
         size = OFF_W'(size_ext);
      end
      if (cfg_plane_count == '0) begin
         count = COUNT_W'(1);
      end else if (cfg_plane_count > COUNT_W'(MAX_PLANES)) begin
         count = COUNT_W'(MAX_PLANES);
      end else begin
         count = cfg_plane_count;
      end
      prefix_lim = (cfg_prefix_bytes > PREFIX_MAX) ? PREFIX_MAX : cfg_prefix_bytes;
   end

   // Repeat length is clamped to what is left of the current plane.
   always_comb begin
      rem     = (offset_cur < size) ? (size - offset_cur) : '0;
      rep_ext = N_W'(state_cur.repeat_count);
      rem_ext = N_W'(rem);
      n_ext   = (rep_ext < rem_ext) ? rep_ext : rem_ext;
   end

   always_comb begin
      st      = state_cur;
      off     = offset_cur;
      emit    = 1'b0;
      off_adv = '0;
      res     = '0;

      if (state_cur.plane < count) begin
         if (st.phase == PH_PREFIX && st.prefix_seen >= prefix_lim) begin
            st.phase = PH_HEADER;
         end
         case (st.phase)
            PH_PREFIX: begin
               st.prefix_seen = st.prefix_seen + PREFIX_W'(1);
            end
            PH_HEADER: begin
               if (src_byte < HDR_REPEAT) begin
                  st.literal_left = src_byte + LEN_W'(1);
                  st.phase        = PH_LITERAL;
               end else begin
                  st.repeat_count = src_byte - HDR_REPEAT + REPEAT_BIAS;
                  st.phase        = PH_REPEAT;
               end
            end
            PH_LITERAL: begin
               if (offset_cur < size) begin
                  off_adv            = offset_cur + OFF_W'(1);
                  emit               = 1'b1;
                  res.run_value      = src_byte;
                  res.run_length     = LEN_W'(1);
                  res.plane_index    = state_cur.plane[PIDX_W-1:0];
                  res.plane_offset   = POFF_W'(offset_cur);
                  res.plane_done     = (off_adv == size);
                  off                = off_adv;
               end
               if (st.literal_left != '0) begin
                  st.literal_left = st.literal_left - LEN_W'(1);
               end
               if (st.literal_left == '0) begin
                  st.phase = PH_HEADER;
                  if (off >= size) begin
                     st.plane = st.plane + PLANE_W'(1);
                     off      = '0;
                  end
               end
            end
            PH_REPEAT: begin
               if (n_ext != '0) begin
                  off_adv          = offset_cur + OFF_W'(n_ext);
                  emit             = 1'b1;
                  res.run_value    = src_byte;
                  res.run_length   = LEN_W'(n_ext);
                  res.plane_index  = state_cur.plane[PIDX_W-1:0];
                  res.plane_offset = POFF_W'(offset_cur);
                  res.plane_done   = (off_adv == size);
                  off              = off_adv;
               end
               st.repeat_count = '0;
               st.phase        = PH_HEADER;
               if (off >= size) begin
                  st.plane = st.plane + PLANE_W'(1);
                  off      = '0;
               end
            end
            default: begin
               st.phase = PH_HEADER;
            end
         endcase
      end

      // The final byte reports a status and returns the decoder to its start.
      if (src_last) begin
         res.final_res = 1'b1;
         if (st.plane >= count) begin
            res.status = ST_OK;
         end else if (cfg_tolerate_last && st.plane == count - COUNT_W'(1)) begin
            res.status = ST_OK;
         end else if (st.phase == PH_LITERAL || st.phase == PH_REPEAT) begin
            res.status = ST_TRUNCATED;
         end else begin
            res.status = ST_MISSING;
         end
         st  = '{phase: PH_PREFIX, prefix_seen: '0, literal_left: '0,
                 repeat_count: '0, plane: '0};
         off = '0;
      end

      state_nxt  = st;
      offset_nxt = off;
      res_valid  = emit || src_last;
   end

endmodule

@@ verif/tb_packbits_multi_plane_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PackBits multi-plane decoder testbench
// Feeds compressed byte streams with random pacing on both channels, predicts
// every decoded run and end status in a local decoder copy, and compares each
// result item, all fields at once, in arrival order.
// ----------------------------------------------------------------------------
module tb_packbits_multi_plane_decoder_top import pbmpd_pkg::*; ;

   localparam int PLANE_BYTES_LIMIT = 16384;
   localparam int PLANE_COUNT_LIMIT = 4;
   localparam int RANDOM_ITEMS      = 700;
   localparam int DRAIN_CYCLES      = 4;
   localparam int HOLD_CYCLES       = 400;
   localparam int STALL_LIMIT       = 3000;
   localparam int REPORT_MAX        = 10;

   typedef logic [BYTE_W-1:0] byte_queue_type[$];
   typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_BLOCKED} rx_mode_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pbmpd_req_if src_ch ();
   pbmpd_rsp_if run_ch ();

   packbits_multi_plane_decoder_top #(
      .MAX_PLANE_BYTES (PLANE_BYTES_LIMIT),
      .MAX_PLANES      (PLANE_COUNT_LIMIT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (src_ch),
      .rsp_if    (run_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Local copy of the register file and of the decoder state.
   logic [SIZE_REG_W-1:0] cfg_plane_size;
   logic [COUNT_W-1:0]    cfg_plane_count;
   logic [PREFIX_W-1:0]   cfg_prefix;
   logic                  cfg_tolerate;
   phase_type             dec_phase;
   int                    prefix_seen;
   int                    literal_left;
   int                    repeat_left;
   int                    plane_off;
   int                    plane_num;

   rsp_data_type expected_runs[$];

   int mismatches    = 0;
   int items_sent    = 0;
   int runs_checked  = 0;
   int streams_sent  = 0;
   int status_seen[3] = '{0, 0, 0};
   int gap_pct       = 30;
   int burst_left    = 0;
   bit hold_req      = 1'b0;
   bit hold_active   = 1'b0;

   function automatic int eff_plane_size();
      if (cfg_plane_size == 0) return 1;
      if (cfg_plane_size > PLANE_BYTES_LIMIT) return PLANE_BYTES_LIMIT;
      return int'(cfg_plane_size);
   endfunction

   function automatic int eff_plane_count();
      if (cfg_plane_count == 0) return 1;
      if (cfg_plane_count > PLANE_COUNT_LIMIT) return PLANE_COUNT_LIMIT;
      return int'(cfg_plane_count);
   endfunction

   function automatic int eff_prefix();
      return (cfg_prefix > PREFIX_MAX) ? int'(PREFIX_MAX) : int'(cfg_prefix);
   endfunction

   function automatic void clear_decoder();
      dec_phase    = PH_PREFIX;
      prefix_seen  = 0;
      literal_left = 0;
      repeat_left  = 0;
      plane_off    = 0;
      plane_num    = 0;
   endfunction

   function automatic string run_text(rsp_data_type r);
      return $sformatf("value=%02h len=%0d plane=%0d off=%0d done=%0b final=%0b status=%0d",
                       r.run_value, r.run_length, r.plane_index, r.plane_offset,
                       r.plane_done, r.final_res, r.status);
   endfunction

   // Advances the local decoder by one compressed byte and queues the run or
   // status item that the byte produces, if any.
   task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic last);
      rsp_data_type r;
      int           size;
      int           count;
      int           rem;
      int           n;
      bit           emit;
      r     = '0;
      emit  = 1'b0;
      size  = eff_plane_size();
      count = eff_plane_count();
      if (plane_num < count) begin
         if (dec_phase == PH_PREFIX && prefix_seen >= eff_prefix()) dec_phase = PH_HEADER;
         case (dec_phase)
            PH_PREFIX: begin
               prefix_seen++;
            end
            PH_HEADER: begin
               if (b < HDR_REPEAT) begin
                  literal_left = int'(b) + 1;
                  dec_phase    = PH_LITERAL;
               end else begin
                  repeat_left = int'(b) - int'(HDR_REPEAT) + int'(REPEAT_BIAS);
                  dec_phase   = PH_REPEAT;
               end
            end
            PH_LITERAL: begin
               if (plane_off < size) begin
                  emit           = 1'b1;
                  r.run_value    = b;
                  r.run_length   = LEN_W'(1);
                  r.plane_index  = PIDX_W'(plane_num);
                  r.plane_offset = POFF_W'(plane_off);
                  plane_off++;
                  r.plane_done   = (plane_off == size);
               end
               if (literal_left > 0) literal_left--;
               if (literal_left == 0) begin
                  dec_phase = PH_HEADER;
                  if (plane_off >= size) begin
                     plane_num++;
                     plane_off = 0;
                  end
               end
            end
            default: begin
               rem = (plane_off < size) ? size - plane_off : 0;
               n   = (repeat_left < rem) ? repeat_left : rem;
               if (n > 0) begin
                  emit           = 1'b1;
                  r.run_value    = b;
                  r.run_length   = LEN_W'(n);
                  r.plane_index  = PIDX_W'(plane_num);
                  r.plane_offset = POFF_W'(plane_off);
                  plane_off     += n;
                  r.plane_done   = (plane_off == size);
               end
               repeat_left = 0;
               dec_phase   = PH_HEADER;
               if (plane_off >= size) begin
                  plane_num++;
                  plane_off = 0;
               end
            end
         endcase
      end
      if (last) begin
         r.final_res = 1'b1;
         if (plane_num >= count) r.status = ST_OK;
         else if (cfg_tolerate && plane_num == count - 1) r.status = ST_OK;
         else if (dec_phase == PH_LITERAL || dec_phase == PH_REPEAT) r.status = ST_TRUNCATED;
         else r.status = ST_MISSING;
         status_seen[r.status]++;
         clear_decoder();
      end
      if (emit || last) expected_runs = {expected_runs, r};
   endtask

   // Offers one byte, with a random gap at the start of each burst, and
   // returns at the edge where it is accepted.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 10) : 0;
         if (gap > 0) begin
            src_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      src_ch.valid    <= 1'b1;
      src_ch.src_byte <= b;
      src_ch.src_last <= last;
      @(posedge clock);
      while (!src_ch.ready) @(posedge clock);
      decode_byte(b, last);
      items_sent++;
   endtask

   // With keep_valid set the next stream must follow at once; otherwise the
   // caller lets time pass before offering anything else.
   task automatic send_stream(input byte_queue_type s, input bit keep_valid);
      foreach (s[i]) send_byte(s[i], i == s.size() - 1);
      if (!keep_valid) src_ch.valid <= 1'b0;
      streams_sent++;
   endtask

   task automatic wait_idle();
      while (expected_runs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_PLANE_SIZE:    cfg_plane_size  = SIZE_REG_W'(value);
         REG_PLANE_COUNT:   cfg_plane_count = COUNT_W'(value);
         REG_PREFIX_BYTES:  cfg_prefix      = PREFIX_W'(value);
         REG_TOLERATE_LAST: cfg_tolerate    = value[0];
         default: ;
      endcase
   endtask

   task automatic set_config(input int size, input int count, input int prefix, input int tol);
      wait_idle();
      write_reg(REG_PLANE_SIZE, size);
      write_reg(REG_PLANE_COUNT, count);
      write_reg(REG_PREFIX_BYTES, prefix);
      write_reg(REG_TOLERATE_LAST, tol);
   endtask

   // Builds a well-formed stream that fills every plane under the current
   // settings. Long runs keep the item count down for the largest planes.
   task automatic build_stream(output byte_queue_type s, input bit long_runs);
      int size;
      int count;
      int off;
      int pl;
      int n;
      bit use_repeat;
      s     = {};
      size  = eff_plane_size();
      count = eff_plane_count();
      repeat (eff_prefix()) s = {s, BYTE_W'($urandom)};
      off = 0;
      pl  = 0;
      while (pl < count) begin
         if (long_runs) use_repeat = ($urandom_range(0, 15) != 0);
         else use_repeat = $urandom_range(0, 1);
         if (use_repeat) begin
            if (long_runs) n = $urandom_range(100, 130);
            else if ($urandom_range(0, 3) == 0) n = $urandom_range(3, 130);
            else n = $urandom_range(3, 10);
            s = {s, HDR_REPEAT + BYTE_W'(n - int'(REPEAT_BIAS))};
            s = {s, BYTE_W'($urandom)};
         end else begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
            s = {s, BYTE_W'(n - 1)};
            repeat (n) s = {s, BYTE_W'($urandom)};
         end
         off += n;
         if (off >= size) begin
            pl++;
            off = 0;
         end
      end
   endtask

   task automatic test_reset_defaults();
      byte_queue_type s;
      // Default planes are far larger than one run, so the stream ends short.
      s = {8'hFF, 8'h00};
      send_stream(s, 1'b0);
   endtask

   task automatic test_run_types();
      byte_queue_type s;
      set_config(4, 2, 1, 0);
      // Prefix byte, two literals, a repeat clamped at the plane end, a literal
      // in the second plane, a long repeat that fills it, then a spare byte.
      s = {8'h5A, 8'h01, 8'h00, 8'hFF, 8'h81, 8'hA5, 8'h00, 8'h7F, 8'hFF, 8'h3C, 8'hC3};
      send_stream(s, 1'b0);
   endtask

   task automatic test_final_status();
      byte_queue_type s;
      set_config(4, 2, 0, 0);
      s = {8'h85};
      send_stream(s, 1'b1);
      s = {8'h02, 8'h11};
      send_stream(s, 1'b1);
      s = {8'h80, 8'h22};
      send_stream(s, 1'b0);
      set_config(4, 2, 0, 1);
      // Cut inside the last plane is tolerated, cut inside the first is not.
      s = {8'h83, 8'h44, 8'h85};
      send_stream(s, 1'b1);
      s = {8'h85};
      send_stream(s, 1'b0);
   endtask

   task automatic test_register_saturation();
      byte_queue_type s;
      // Size and count clamp to one, the prefix clamps to four bytes. Literal
      // bytes past the single-byte plane are swallowed.
      set_config(0, 0, 7, 0);
      s = {8'hF0, 8'h0F, 8'hAA, 8'h55, 8'h03, 8'hE1, 8'h1E, 8'h99, 8'h66};
      send_stream(s, 1'b0);
   endtask

   task automatic test_midstream_resize();
      byte_queue_type s;
      set_config(8, 2, 0, 0);
      // A five byte run, with the stream left open behind it.
      send_byte(8'h82, 1'b0);
      send_byte(8'h55, 1'b0);
      src_ch.valid <= 1'b0;
      wait_idle();
      // The offset is now past the plane end, so the next repeat has no room.
      write_reg(REG_PLANE_SIZE, 4);
      s = {8'h80, 8'h66, 8'h9A};
      send_stream(s, 1'b0);
   endtask

   task automatic test_largest_planes();
      byte_queue_type s;
      set_config(32767, 1, 0, 0);
      build_stream(s, 1'b1);
      send_stream(s, 1'b0);
   endtask

   task automatic test_result_backpressure();
      byte_queue_type s;
      set_config(64, 1, 0, 0);
      s = {8'h3F};
      repeat (64) s = {s, BYTE_W'($urandom)};
      gap_pct  = 0;
      hold_req = 1'b1;
      wait (hold_active);
      send_stream(s, 1'b0);
   endtask

   task automatic test_random_streams();
      byte_queue_type s;
      int             start_items;
      int             ending;
      int             k;
      int             size;
      bit             chain;
      start_items = items_sent;
      chain       = 1'b0;
      while (items_sent - start_items < RANDOM_ITEMS) begin
         if (!chain) begin
            gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
            if ($urandom_range(0, 2) != 0) begin
               k = $urandom_range(0, 19);
               if (k == 0) size = 0;
               else if (k == 1) size = $urandom_range(49, 200);
               else if (k < 5) size = $urandom_range(1, 4);
               else size = $urandom_range(1, 48);
               set_config(size, $urandom_range(0, 7), $urandom_range(0, 7),
                          $urandom_range(0, 1));
            end else begin
               wait_idle();
            end
         end
         build_stream(s, 1'b0);
         ending = $urandom_range(0, 9);
         if (ending >= 7) s = s[0:$urandom_range(0, s.size() - 1)];
         else if (ending == 6) repeat ($urandom_range(1, 3)) s = {s, BYTE_W'($urandom)};
         chain = (items_sent - start_items + s.size() < RANDOM_ITEMS) &&
                 ($urandom_range(0, 3) == 0);
         send_stream(s, chain);
      end
   endtask

   // Receiver pacing: segments of open, random, sparse and blocked ready,
   // plus one long hold-off on request.
   initial begin : rsp_stall_pattern
      rx_mode_type mode;
      int          len;
      forever begin
         if (hold_req) begin
            hold_req    = 1'b0;
            hold_active = 1'b1;
            run_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active = 1'b0;
         end else begin
            mode = rx_mode_type'($urandom_range(0, 3));
            len  = $urandom_range(4, 40);
            repeat (len) begin
               case (mode)
                  RX_OPEN:   run_ch.ready <= 1'b1;
                  RX_RANDOM: run_ch.ready <= 1'($urandom_range(0, 1));
                  RX_SPARSE: run_ch.ready <= ($urandom_range(0, 3) == 0);
                  default:   run_ch.ready <= 1'b0;
               endcase
               @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin : run_check
      rsp_data_type got;
      rsp_data_type want;
      if (!reset && run_ch.valid && run_ch.ready) begin
         got = {run_ch.run_value, run_ch.run_length, run_ch.plane_index, run_ch.plane_offset,
                run_ch.plane_done, run_ch.final_res, run_ch.status};
         if (expected_runs.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("Unexpected result at %0t: %s", $time, run_text(got));
         end else begin
            want = expected_runs.pop_front();
            runs_checked++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("Run mismatch at %0t: expected %s, got %s",
                           $time, run_text(want), run_text(got));
            end
         end
      end
   end

   initial begin : stall_watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((src_ch.valid && src_ch.ready) || (run_ch.valid && run_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("No item moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, expected_runs.size());
      $display("tb_packbits_multi_plane_decoder_top: FAIL");
      $finish;
   end

   initial begin : stimulus
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_index       <= REG_PLANE_SIZE;
      csr_wdata       <= '0;
      src_ch.valid    <= 1'b0;
      src_ch.src_byte <= '0;
      src_ch.src_last <= 1'b0;
      cfg_plane_size  = RST_PLANE_SIZE;
      cfg_plane_count = RST_PLANE_COUNT;
      cfg_prefix      = RST_PREFIX;
      cfg_tolerate    = RST_TOLERATE;
      clear_decoder();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_run_types();
      test_final_status();
      test_register_saturation();
      test_midstream_resize();
      test_largest_planes();
      test_result_backpressure();
      test_random_streams();
      wait_idle();

      if (expected_runs.size() != 0) begin
         mismatches++;
         $display("%0d expected results never arrived", expected_runs.size());
      end
      $display("Sent %0d streams, %0d bytes; checked %0d results, %0d mismatches",
               streams_sent, items_sent, runs_checked, mismatches);
      $display("End status seen: ok %0d, truncated %0d, planes missing %0d",
               status_seen[ST_OK], status_seen[ST_TRUNCATED], status_seen[ST_MISSING]);
      if (mismatches == 0) begin
         $display("tb_packbits_multi_plane_decoder_top: PASS");
      end else begin
         $display("tb_packbits_multi_plane_decoder_top: FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/pbmpd_pkg.sv
src/pbmpd_if.sv
src/pbmpd_step.sv
src/packbits_multi_plane_decoder_top.sv
verif/tb_packbits_multi_plane_decoder_top.sv
